### hdl/igd_pkg.sv
// Package: constants, types and helpers for the inverted generational distance block.
package igd_pkg;

  localparam int MaxSolutions  = 256;
  localparam int MaxObjectives = 4;
  localparam int MaxReferences = 4096;
  localparam int AddrW         = $clog2(MaxSolutions);
  localparam int ScntW         = $clog2(MaxSolutions + 1);
  localparam int RcntW         = $clog2(MaxReferences + 1);
  localparam int SumW          = 30;
  localparam int SqW           = 36;
  localparam int RootW         = 18;
  localparam logic [SumW-1:0] SumLimit = {SumW{1'b1}};

  typedef logic [63:0] point_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // Active objective count after clamping to the legal range.
  function automatic logic [2:0] active_obj(input logic [2:0] n);
    logic [2:0] r;
    r = n;
    if (r == 3'd0) r = 3'd1;
    if (r > 3'(MaxObjectives)) r = 3'(MaxObjectives);
    return r;
  endfunction

endpackage

### hdl/inverted_generational_distance_top.sv
// Top level: solution store, nearest-distance scan, square root, sum and mean.
// Solution loads are accepted while idle. A reference point scans every stored
// solution from the store RAM, one entry a cycle, through the read register,
// the distance register and an 18-step square root; the point carrying
// last_reference adds a 30-step divider for the mean and holds its result in
// an output register until transferred.
module inverted_generational_distance_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [15:0] in_coord_a,
  input  logic [15:0] in_coord_b,
  input  logic [15:0] in_coord_c,
  input  logic [15:0] in_coord_d,
  input  logic        in_last_reference,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_mean_distance,
  output logic [12:0] out_reference_total,
  output logic        out_no_solutions,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_num_objectives
);

  localparam int AW = igd_pkg::AddrW;
  localparam int SW = igd_pkg::SqW;
  localparam int RW = igd_pkg::RootW;
  localparam int UW = igd_pkg::SumW;
  localparam int CW = igd_pkg::RcntW;

  igd_pkg::state_t state_r, state_nxt;
  logic [2:0]  nobj_r;
  logic [igd_pkg::ScntW-1:0] scnt_r;
  logic [CW-1:0] rcnt_r;
  logic [UW-1:0] sum_r;
  igd_pkg::point_t refp_r;
  logic          last_r, counted_r;

  // Store RAM
  igd_pkg::point_t mem [igd_pkg::MaxSolutions];
  igd_pkg::point_t rd_r;
  logic [AW-1:0] raddr;
  logic [igd_pkg::ScntW-1:0] idx_r;   // next address to issue
  logic          rdv_r, sqv_r;        // read data valid, distance valid
  logic [igd_pkg::ScntW-1:0] seen_r;  // distances folded in
  logic [SW-1:0] sq, best_r;
  logic          have_best_r;

  // Square root and divider
  logic [SW-1:0] rem_r;
  logic [RW-1:0] root_r;
  logic          rv_r;
  logic [4:0]    step_r;
  logic [UW-1:0] quo_r;
  logic [CW:0]   drem_r;

  logic in_xfer, out_xfer;
  logic [RW-1:0] trial_root;
  logic [RW-1:0] root_fin;
  logic [SW-1:0] trial;
  logic [CW:0]   dtry;
  logic          full_ref;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = (state_r != igd_pkg::ST_IDLE);
  assign cfg_ready = (state_r == igd_pkg::ST_IDLE);
  assign out_valid = (state_r == igd_pkg::ST_OUT);
  assign raddr     = idx_r[AW-1:0];
  assign full_ref  = (rcnt_r == CW'(igd_pkg::MaxReferences));

  always_ff @(posedge clk) begin
    if (in_xfer && !in_func && scnt_r != igd_pkg::ScntW'(igd_pkg::MaxSolutions))
      mem[scnt_r[AW-1:0]] <= {in_coord_d, in_coord_c, in_coord_b, in_coord_a};
    rd_r <= mem[raddr];
  end

  igd_dist u_dist (
    .clk    (clk),
    .nobj   (igd_pkg::active_obj(nobj_r)),
    .sol    (rd_r),
    .ref_pt (refp_r),
    .sq_r   (sq)
  );

  // Bit-pair square root step
  assign trial_root = root_r | RW'(1'b1) << step_r;
  assign trial = SW'({root_r, 1'b0} << step_r) | (SW'(1) << (2*step_r));
  assign root_fin = root_r | ((rem_r >= trial) ? RW'(1) : RW'(0));
  // Restoring division step
  assign dtry  = {drem_r[CW-1:0], quo_r[UW-1]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      igd_pkg::ST_IDLE:
        if (in_xfer && in_func) state_nxt = igd_pkg::ST_SCAN;
      igd_pkg::ST_SCAN:
        if (seen_r == scnt_r && !rdv_r && !sqv_r) state_nxt = igd_pkg::ST_ROOT;
      igd_pkg::ST_ROOT:
        if (step_r == 5'd0) state_nxt = last_r ? igd_pkg::ST_DIV : igd_pkg::ST_IDLE;
      igd_pkg::ST_DIV:
        if (step_r == 5'd0) state_nxt = igd_pkg::ST_OUT;
      igd_pkg::ST_OUT:
        if (out_xfer) state_nxt = igd_pkg::ST_IDLE;
      default: state_nxt = igd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= igd_pkg::ST_IDLE;
      nobj_r  <= 3'd2;
      scnt_r  <= '0;
      rcnt_r  <= '0;
      sum_r   <= '0;
      rdv_r   <= 1'b0;
      sqv_r   <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) nobj_r <= cfg_num_objectives;
      rdv_r <= (state_r == igd_pkg::ST_SCAN) && (idx_r != scnt_r);
      sqv_r <= rdv_r;
      unique case (state_r)
        igd_pkg::ST_IDLE:
          if (in_xfer) begin
            if (!in_func) begin
              if (scnt_r != igd_pkg::ScntW'(igd_pkg::MaxSolutions))
                scnt_r <= scnt_r + 1'b1;
            end else begin
              refp_r <= {in_coord_d, in_coord_c, in_coord_b, in_coord_a};
              last_r <= in_last_reference;
              counted_r <= !full_ref;
              idx_r <= '0;
              seen_r <= '0;
              have_best_r <= 1'b0;
              best_r <= '0;
            end
          end
        igd_pkg::ST_SCAN: begin
          // issue reads, fold distances as they return
          if (idx_r != scnt_r) idx_r <= idx_r + 1'b1;
          if (sqv_r) begin
            seen_r <= seen_r + 1'b1;
            if (!have_best_r || sq < best_r) best_r <= sq;
            have_best_r <= 1'b1;
          end
          if (state_nxt == igd_pkg::ST_ROOT) begin
            rem_r  <= best_r;
            root_r <= '0;
            step_r <= 5'(RW - 1);
          end
        end
        igd_pkg::ST_ROOT: begin
          if (rem_r >= trial) begin
            rem_r  <= rem_r - trial;
            root_r <= trial_root;
          end
          if (step_r != 5'd0) step_r <= step_r - 1'b1;
          else begin
            if (counted_r) begin
              sum_r  <= (33'(sum_r) + 33'(root_fin) > 33'(igd_pkg::SumLimit))
                        ? igd_pkg::SumLimit
                        : UW'(sum_r + UW'(root_fin));
              rcnt_r <= rcnt_r + 1'b1;
            end
            step_r <= 5'(UW - 1);
          end
        end
        igd_pkg::ST_DIV: begin
          if (step_r == 5'(UW - 1) && !rv_r) begin
            quo_r  <= sum_r;
            drem_r <= '0;
            rv_r   <= 1'b1;
          end else begin
            if (dtry >= {1'b0, rcnt_r}) begin
              drem_r <= dtry - {1'b0, rcnt_r};
              quo_r  <= {quo_r[UW-2:0], 1'b1};
            end else begin
              drem_r <= dtry;
              quo_r  <= {quo_r[UW-2:0], 1'b0};
            end
            if (step_r != 5'd0) step_r <= step_r - 1'b1;
          end
        end
        igd_pkg::ST_OUT:
          if (out_xfer) begin
            scnt_r <= '0;
            rcnt_r <= '0;
            sum_r  <= '0;
            rv_r   <= 1'b0;
          end
        default: ;
      endcase
    end
  end

  assign out_mean_distance   = (rcnt_r == '0) ? 17'd0 : quo_r[16:0];
  assign out_reference_total = rcnt_r[12:0];
  assign out_no_solutions    = (scnt_r == '0);

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == igd_pkg::ST_SCAN |-> seen_r <= scnt_r)
    else $error("more distances folded than solutions");
  assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= igd_pkg::SumLimit)
    else $error("sum above limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |=> rcnt_r == '0 && scnt_r == '0)
    else $error("counters not cleared after result");
  assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= CW'(igd_pkg::MaxReferences))
    else $error("reference count overrun");

endmodule

### hdl/igd_dist.sv
// Squared-distance datapath: difference, square and sum over active objectives, registered.
module igd_dist (
  input  logic                    clk,
  input  logic [2:0]              nobj,
  input  igd_pkg::point_t         sol,
  input  igd_pkg::point_t         ref_pt,
  output logic [igd_pkg::SqW-1:0] sq_r
);

  logic [igd_pkg::SqW-1:0] sq_nxt;

  always_comb begin
    logic signed [16:0] d;
    logic [33:0]        p;
    sq_nxt = '0;
    for (int k = 0; k < igd_pkg::MaxObjectives; k++) begin
      d = 17'(signed'(sol[16*k +: 16])) - 17'(signed'(ref_pt[16*k +: 16]));
      p = 34'(d * d);
      if (k < int'(nobj)) sq_nxt = sq_nxt + igd_pkg::SqW'(p);
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

endmodule
